// ===== rtl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants and control types for the moving average with warm-up.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // Width of one sample and of one mean.
    localparam int SAMPLE_W   = 16;

    // Default number of samples in the averaging window.
    localparam int WINDOW_DEF = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming sample
        logic update;    // replace the oldest entry, update the sum, load the divider
        logic div_step;  // one restoring division step
        logic out_load;  // move the quotient into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;  // the current division step is the final one
    } status_t;

endpackage

// ===== rtl/mavg_sample_if.sv =====
// ----------------------------------------------------------------------------
// mavg_sample_if
// Valid/ready channel that carries one input sample per item.
// ----------------------------------------------------------------------------
interface mavg_sample_if;

    logic                          valid;
    logic                          ready;
    logic [mavg_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ===== rtl/mavg_mean_if.sv =====
// ----------------------------------------------------------------------------
// mavg_mean_if
// Valid/ready channel that carries one mean per item.
// ----------------------------------------------------------------------------
interface mavg_mean_if;

    logic                          valid;
    logic                          ready;
    logic [mavg_pkg::SAMPLE_W-1:0] mean;

    modport source (output valid, output mean, input ready);
    modport sink   (input valid, input mean, output ready);

endinterface

// ===== rtl/mavg_ram.sv =====
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mavg_datapath.sv =====
// ----------------------------------------------------------------------------
// mavg_datapath
// Sample ring, running sum, window position and restoring divider.
// ----------------------------------------------------------------------------
module mavg_datapath #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mavg_pkg::cmd_t                cmd,
    output mavg_pkg::status_t             status,
    input  logic [mavg_pkg::SAMPLE_W-1:0] sample_in,
    output logic [mavg_pkg::SAMPLE_W-1:0] mean_out
);

    localparam int SW    = mavg_pkg::SAMPLE_W;
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SW + POS_W;
    localparam int DIV_W = $clog2(WINDOW + 1);
    localparam int STP_W = $clog2(SUM_W);

    logic [SW-1:0]    sample_reg;
    logic [SUM_W-1:0] sum_reg,  sum_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic             full_reg, full_next;
    logic [SUM_W-1:0] dvd_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic [STP_W-1:0] step_reg;
    logic [SW-1:0]    mean_reg;

    logic [SW-1:0]    ram_rdata;
    logic [SW-1:0]    old_sample;
    logic [DIV_W-1:0] count;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // Ring of the most recent samples; read at the write position.
    mavg_ram #(
        .WIDTH  (SW),
        .DEPTH  (WINDOW),
        .ADDR_W (POS_W)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // Until the ring has wrapped, the overwritten entry counts as zero; the RAM itself has no reset.
    assign old_sample = full_reg ? ram_rdata : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);

    // Position advance with wrap; a wrap marks the window as full.
    always_comb
    begin
        if (pos_reg == POS_W'(WINDOW - 1))
        begin
            pos_next  = '0;
            full_next = 1'b1;
        end
        else
        begin
            pos_next  = pos_reg + 1'b1;
            full_next = full_reg;
        end
    end

    // Divisor: samples taken so far during warm-up, the window size afterward.
    assign count        = DIV_W'(pos_reg) + 1'b1;
    assign divisor_next = full_next ? DIV_W'(WINDOW) : count;

    // One restoring division step.
    assign shifted = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    // Window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            sum_reg  <= sum_next;
            pos_reg  <= pos_next;
            full_reg <= full_next;
        end
    end

    // Sample latch, divider and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.update)
        begin
            dvd_reg     <= sum_next;
            rem_reg     <= '0;
            divisor_reg <= divisor_next;
            step_reg    <= STP_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff[DIV_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            end
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            mean_reg <= dvd_reg[SW-1:0];
        end
    end

    assign status.div_last = (step_reg == '0);
    assign mean_out        = mean_reg;

endmodule

// ===== rtl/mavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer for one item: accept, update, divide, hand over the result.
// ----------------------------------------------------------------------------
module mavg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mavg_pkg::cmd_t    cmd,
    input  mavg_pkg::status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // The output register can take a new mean when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Commands decoded from the current state.
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // State and output-valid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/moving_average_warmup.sv =====
// ----------------------------------------------------------------------------
// moving_average_warmup
// Moving average over a ring of the last WINDOW samples, with a warm-up
// divisor equal to the number of samples taken until the ring first fills.
//
//   Channel     Direction  Payload        Width
//   sample_ch   in         sample         16, unsigned
//   mean_ch     out        mean           16, unsigned
//
// After acceptance, each item passes the update state and then the
// one-bit-per-cycle restoring divider, which works through all SUM_W bits
// of the sum (SUM_W = 16 + log2(WINDOW)), before the mean is loaded into
// the output register; the next sample is taken only after that load. One
// item is in work at a time; a finished mean waits in the output register
// while the next sample is taken. A stalled output holds the block in its
// final state once the next quotient is done. Reset clears the sum, the
// position and the full flag; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module moving_average_warmup #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    mavg_sample_if.sink  sample_ch,
    mavg_mean_if.source  mean_ch
);

    mavg_pkg::cmd_t    cmd;
    mavg_pkg::status_t status;

    // Controller.
    mavg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (mean_ch.valid),
        .out_ready (mean_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath.
    mavg_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_in (sample_ch.sample),
        .mean_out  (mean_ch.mean)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for moving_average_warmup. A directed table covers
// the warm-up divisor, the first wrap of the ring and full-scale samples.
// Random samples follow, with random idle gaps and output stalls. Each
// accepted mean is compared with the value that a local model of the window
// predicts for the matching accepted sample.
// ----------------------------------------------------------------------------
module tb;

    localparam int SAMPLE_W     = mavg_pkg::SAMPLE_W;
    localparam int WINDOW       = mavg_pkg::WINDOW_DEF;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 40;
    localparam int PRINT_CAP    = 50;

    // One row of the directed table; a typed mean replaces the model's value.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        logic [SAMPLE_W-1:0] mean;
    } row_t;

    // The first three rows use the warm-up divisor: one, two and three samples.
    // Rows 4 to 16 fill the ring, and row 16 wraps it. Rows 17 to 19 replace the
    // first three entries, pushing out the zero and the one, so that the ring then holds only full-scale values.
    localparam int N_ROWS = 24;
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{16'hFFFF, 1'b1, 16'hFFFF},
        '{16'h0000, 1'b1, 16'd32767},
        '{16'h0001, 1'b1, 16'd21845},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b1, 16'hFFFF},
        '{16'h0000, 1'b0, 16'h0000},
        '{16'hAAAA, 1'b0, 16'h0000},
        '{16'h5555, 1'b0, 16'h0000},
        '{16'h8000, 1'b0, 16'h0000},
        '{16'h7FFF, 1'b0, 16'h0000}
    };

    logic clk = 1'b0;
    logic rst_n;

    mavg_sample_if sample_ch ();
    mavg_mean_if   mean_ch ();

    moving_average_warmup #(
        .WINDOW (WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .mean_ch   (mean_ch)
    );

    // Window model: ring, oldest position, full flag and running sum.
    logic [SAMPLE_W-1:0] win_ring [WINDOW] = '{default: '0};
    int                  win_pos  = 0;
    logic                win_full = 1'b0;
    logic [SUM_W-1:0]    win_sum  = '0;

    logic [SAMPLE_W-1:0] pending_means [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    logic                send_calm = 1'b0;
    logic                recv_calm = 1'b0;

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Global watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Adds one sample to the window model and returns the new mean.
    function automatic logic [SAMPLE_W-1:0] advance_window(input logic [SAMPLE_W-1:0] s);
        int divisor;
        win_sum = win_sum - SUM_W'(win_ring[win_pos]) + SUM_W'(s);
        win_ring[win_pos] = s;
        if (win_pos == WINDOW - 1)
        begin
            win_pos  = 0;
            win_full = 1'b1;
        end
        else
        begin
            win_pos = win_pos + 1;
        end
        divisor = win_full ? WINDOW : win_pos;
        return SAMPLE_W'(win_sum / divisor);
    endfunction

    // Idle length: mostly none or short, now and then long, none while calm.
    function automatic int idle_length(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Random sample: mostly uniform, with extremes and edge bands mixed in.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            5:       return '0;
            6:       return '1;
            7:       return SAMPLE_W'($urandom_range(0, 15));
            8:       return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                   input logic [SAMPLE_W-1:0] got);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                     cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // Presents one sample after a random gap and records its expected mean
    // once the item is accepted.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input logic [SAMPLE_W-1:0] typed_mean);
        int gap;
        logic [SAMPLE_W-1:0] predicted;
        gap = idle_length(send_calm);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = advance_window(s);
        pending_means.push_back(typed ? typed_mean : predicted);
    endtask

    // Holds the input idle until every expected mean has been taken.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0)
            @(posedge clk);
    endtask

    // Output side: ready with random stalls, with calm stretches now and then.
    initial
    begin
        int stall;
        mean_ch.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                recv_calm = ~recv_calm;
            stall = idle_length(recv_calm);
            if (stall > 0)
            begin
                mean_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mean_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Compares each accepted mean with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && mean_ch.valid && mean_ch.ready)
        begin
            if (pending_means.size() == 0)
                report_mismatch("mean with no sample pending", '0, mean_ch.mean);
            else
            begin
                if (mean_ch.mean !== pending_means[0])
                    report_mismatch("mean", pending_means[0], mean_ch.mean);
                pending_means.pop_front();
            end
        end
    end

    // Reset, directed table, random samples, then drain and verdict.
    initial
    begin
        int run_left;
        int drain_cycles;
        logic [SAMPLE_W-1:0] run_value;
        logic [SAMPLE_W-1:0] s;

        run_left  = 0;
        run_value = '0;
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].mean);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 350 == 175)
                wait_for_drain();
            if ($urandom_range(0, 99) == 0)
                send_calm = ~send_calm;
            // Occasional runs of one value settle the whole window on it.
            if (run_left == 0 && $urandom_range(0, 49) == 0)
            begin
                run_left  = $urandom_range(WINDOW, 2 * WINDOW);
                run_value = random_sample();
            end
            if (run_left > 0)
            begin
                s = run_value;
                run_left--;
            end
            else
            begin
                s = random_sample();
            end
            send_sample(s, 1'b0, '0);
        end
        sample_ch.valid <= 1'b0;

        drain_cycles = 0;
        while (pending_means.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_means.size() != 0)
            report_mismatch("means never delivered", SAMPLE_W'(pending_means.size()), '0);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== moving_average_warmup.f =====
rtl/mavg_pkg.sv
rtl/mavg_sample_if.sv
rtl/mavg_mean_if.sv
rtl/mavg_ram.sv
rtl/mavg_datapath.sv
rtl/mavg_ctrl.sv
rtl/moving_average_warmup.sv
verif/tb.sv
